[design/mch_pkg.sv]
// shared constants, types and angle table for the calibrated heading core
// no dependencies
package mch_pkg;

   localparam int ScaleFracBits   = 14;
   localparam int HeadingFracBits = 6;
   localparam int CordicSteps     = 16;
   localparam int AngFrac         = 20;

   // corrected axis: (2*raw - off2) is 19 bits signed, times 16 bit scale -> 35 bits
   // shifted by AngFrac and grown by cordic gain -> 58 bits
   localparam int CordW  = 58;
   localparam int AngW   = 32;
   localparam int StepW  = 5;

   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_START  = 2'd1;
   localparam logic [1:0] REQ_STOP   = 2'd2;

   localparam logic signed [AngW-1:0] Deg180 = AngW'(64'sd180 <<< AngFrac);
   localparam logic signed [AngW-1:0] Deg360 = AngW'(64'sd360 <<< AngFrac);
   localparam logic [14:0] FullHeading = 15'(360 << HeadingFracBits);

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture item; corrected x/y hold while it is high
      logic cordic_init; // load cordic registers
      logic cordic_step; // one rotation
      logic finish;      // form heading
      logic div_init;    // start scale divide for current axis
      logic div_step;    // one quotient bit
      logic div_store;   // store scale of current axis
      logic [1:0] axis;
      logic apply_off;   // store offsets
      logic upd_ext;     // update extremes
      logic clr_ext;     // clear extremes
   } cmd_type;

   typedef struct packed {
      logic zero_vec;
      logic range_bad;
      logic range_low;
   } sts_type;

   function automatic logic signed [AngW-1:0] atan_lut(input logic [StepW-1:0] i);
      logic signed [AngW-1:0] r;
      begin
         case (i)
            5'd0:  r = 32'sd47185920;
            5'd1:  r = 32'sd27855475;
            5'd2:  r = 32'sd14718068;
            5'd3:  r = 32'sd7471121;
            5'd4:  r = 32'sd3750058;
            5'd5:  r = 32'sd1876857;
            5'd6:  r = 32'sd938658;
            5'd7:  r = 32'sd469357;
            5'd8:  r = 32'sd234682;
            5'd9:  r = 32'sd117342;
            5'd10: r = 32'sd58671;
            5'd11: r = 32'sd29335;
            5'd12: r = 32'sd14668;
            5'd13: r = 32'sd7334;
            5'd14: r = 32'sd3667;
            5'd15: r = 32'sd1833;
            5'd16: r = 32'sd917;
            5'd17: r = 32'sd458;
            5'd18: r = 32'sd229;
            5'd19: r = 32'sd115;
            5'd20: r = 32'sd57;
            5'd21: r = 32'sd29;
            5'd22: r = 32'sd14;
            5'd23: r = 32'sd7;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

[design/mch_datapath.sv]
// datapath: calibration state, corrected axes, cordic and scale divider
// depends on mch_pkg
module mch_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mch_pkg::cmd_type    cmd,
   input  logic [15:0]         in_x,
   input  logic [15:0]         in_y,
   input  logic [15:0]         in_z,
   input  logic [15:0]         threshold,
   output mch_pkg::sts_type    sts,
   output logic [14:0]         heading
);

   logic signed [15:0] mag_ff [3];
   logic signed [15:0] mag_in [3];
   logic signed [15:0] min_ff [3];
   logic signed [15:0] min_in [3];
   logic signed [15:0] max_ff [3];
   logic signed [15:0] max_in [3];
   logic signed [16:0] off_ff [3];
   logic signed [16:0] off_in [3];
   logic [15:0]        scl_ff [3];
   logic [15:0]        scl_in [3];

   logic signed [34:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [mch_pkg::CordW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [mch_pkg::AngW-1:0]  z_ff, z_in;
   logic [mch_pkg::StepW-1:0]        i_ff, i_in;
   logic [14:0]                      hd_ff, hd_in;

   // divider: quotient of (sum<<frac + den/2) / den, restoring, 33 bits
   localparam int NumW = 18 + mch_pkg::ScaleFracBits + 1;
   logic [NumW-1:0] rem_ff, rem_in, num_ff, num_in;
   logic [NumW-1:0] quo_ff, quo_in;
   logic [NumW-1:0] den;
   logic [NumW:0]   trial;

   logic signed [16:0] rng [3];
   logic [17:0]        rsum;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         rng[a] = 17'(max_ff[a]) - 17'(min_ff[a]);
      end
      rsum = 18'(rng[0][15:0]) + 18'(rng[1][15:0]) + 18'(rng[2][15:0]);
      sts.range_bad = 1'b0;
      sts.range_low = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (rng[a] <= 0) sts.range_bad = 1'b1;
         if (rng[a] < $signed({1'b0, threshold})) sts.range_low = 1'b1;
      end
      sts.zero_vec = (cx_ff == '0) && (cy_ff == '0);
   end

   // corrected axes, one multiplier each, registered
   logic signed [18:0] dx, dy;
   always_comb begin
      dx = 19'($signed({mag_ff[0], 1'b0})) - 19'(off_ff[0]);
      dy = 19'($signed({mag_ff[1], 1'b0})) - 19'(off_ff[1]);
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (cmd.cordic_init == 1'b0 && cmd.load == 1'b0) begin
         cx_in = 35'(dx * $signed({1'b0, scl_ff[0]}));
         cy_in = 35'(dy * $signed({1'b0, scl_ff[1]}));
      end
   end

   // cordic
   logic signed [mch_pkg::CordW-1:0] xs, ys;
   logic signed [mch_pkg::AngW-1:0]  zw;
   logic signed [mch_pkg::AngW-1:0]  zr;
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      hd_in = hd_ff;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      zw = '0;
      zr = '0;
      if (cmd.load) begin
         hd_in = '0;
      end
      if (cmd.cordic_init) begin
         i_in = '0;
         if (cx_ff < 0) begin
            x_in = -(mch_pkg::CordW'(cx_ff) <<< mch_pkg::AngFrac);
            y_in = -(mch_pkg::CordW'(cy_ff) <<< mch_pkg::AngFrac);
            z_in = mch_pkg::Deg180;
         end else begin
            x_in = mch_pkg::CordW'(cx_ff) <<< mch_pkg::AngFrac;
            y_in = mch_pkg::CordW'(cy_ff) <<< mch_pkg::AngFrac;
            z_in = '0;
         end
      end else if (cmd.cordic_step) begin
         i_in = i_ff + 1'b1;
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + mch_pkg::atan_lut(i_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - mch_pkg::atan_lut(i_ff);
         end
      end else if (cmd.finish) begin
         zw = z_ff;
         if (zw < 0) zw = zw + mch_pkg::Deg360;
         if (zw >= mch_pkg::Deg360) zw = zw - mch_pkg::Deg360;
         zr = (zw + (mch_pkg::AngW'(1) <<< (mch_pkg::AngFrac - mch_pkg::HeadingFracBits - 1)))
              >>> (mch_pkg::AngFrac - mch_pkg::HeadingFracBits);
         if (sts.zero_vec) hd_in = '0;
         else if (zr[14:0] >= mch_pkg::FullHeading) hd_in = zr[14:0] - mch_pkg::FullHeading;
         else hd_in = zr[14:0];
      end
   end

   // scale divider
   always_comb begin
      den = NumW'(rng[cmd.axis][15:0]) * NumW'(3);
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      trial = '0;
      if (cmd.div_init) begin
         rem_in = '0;
         num_in = (NumW'(rsum) << mch_pkg::ScaleFracBits) + (den >> 1);
         quo_in = '0;
      end else if (cmd.div_step) begin
         trial = {rem_ff, num_ff[NumW-1]} - {1'b0, den};
         num_in = num_ff << 1;
         if (!trial[NumW]) begin
            rem_in = trial[NumW-1:0];
            quo_in = {quo_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[NumW-2:0], num_ff[NumW-1]};
            quo_in = {quo_ff[NumW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         mag_in[a] = mag_ff[a];
         min_in[a] = min_ff[a];
         max_in[a] = max_ff[a];
         off_in[a] = off_ff[a];
         scl_in[a] = scl_ff[a];
      end
      if (cmd.load) begin
         mag_in[0] = in_x;
         mag_in[1] = in_y;
         mag_in[2] = in_z;
      end
      for (int a = 0; a < 3; a++) begin
         if (cmd.clr_ext) begin
            min_in[a] = 16'sh7fff;
            max_in[a] = -16'sh8000;
         end else if (cmd.upd_ext) begin
            if (mag_ff[a] < min_ff[a]) min_in[a] = mag_ff[a];
            if (mag_ff[a] > max_ff[a]) max_in[a] = mag_ff[a];
         end
         if (cmd.apply_off) off_in[a] = 17'(max_ff[a]) + 17'(min_ff[a]);
      end
      if (cmd.div_store) begin
         scl_in[cmd.axis] = (quo_ff > NumW'(65535)) ? 16'hffff : quo_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= 16'sh7fff;
            max_ff[a] <= -16'sh8000;
            off_ff[a] <= '0;
            scl_ff[a] <= 16'(1 << mch_pkg::ScaleFracBits);
         end
         hd_ff <= '0;
      end else begin
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= min_in[a];
            max_ff[a] <= max_in[a];
            off_ff[a] <= off_in[a];
            scl_ff[a] <= scl_in[a];
         end
         hd_ff <= hd_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) mag_ff[a] <= mag_in[a];
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      i_ff   <= i_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign heading = hd_ff;

endmodule

[design/mch_ctrl.sv]
// controller: sequences one item through the datapath and holds the result valid and flags
// depends on mch_pkg
module mch_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_kind,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              cal_active,
   output logic              low_range,
   output logic              cal_applied,
   output mch_pkg::cmd_type  cmd,
   input  mch_pkg::sts_type  sts
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_INIT = 3'd2;
   localparam logic [2:0] ST_ROT  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   localparam int DivSteps = 18 + mch_pkg::ScaleFracBits + 1;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] axis_ff, axis_in;
   logic       coll_ff, coll_in;
   logic       low_ff, low_in;
   logic       appl_ff, appl_in;
   logic       vld_ff, vld_in;
   logic       accept;

   // a waiting result keeps the input closed, its fields are live state
   assign req_tready = (state_ff == ST_IDLE) && !vld_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      coll_in  = coll_ff;
      low_in   = low_ff;
      appl_in  = appl_ff;
      vld_in   = vld_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      if (rsp_tvalid && rsp_tready) vld_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept) begin
               kind_in  = req_kind;
               low_in   = 1'b0;
               appl_in  = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // corrected products register this cycle
            case (kind_ff)
               mch_pkg::REQ_SAMPLE: begin
                  state_in = ST_INIT;
               end
               mch_pkg::REQ_START: begin
                  if (!coll_ff) begin
                     coll_in     = 1'b1;
                     cmd.clr_ext = 1'b1;
                  end
                  state_in = ST_OUT;
               end
               mch_pkg::REQ_STOP: begin
                  state_in = ST_OUT;
                  if (coll_ff) begin
                     coll_in = 1'b0;
                     low_in  = sts.range_low || sts.range_bad;
                     if (!sts.range_bad) begin
                        axis_in  = 2'd0;
                        cmd.axis = 2'd0;
                        cmd.div_init = 1'b1;
                        cnt_in   = '0;
                        state_in = ST_DIV;
                     end
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_INIT: begin
            cmd.cordic_init = 1'b1;
            cmd.upd_ext     = coll_ff;
            cnt_in          = '0;
            state_in        = ST_ROT;
         end
         ST_ROT: begin
            cmd.cordic_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(mch_pkg::CordicSteps - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_DIV: begin
            if (cnt_ff == 6'(DivSteps)) begin
               cmd.div_store = 1'b1;
               if (axis_ff == 2'd2) begin
                  cmd.apply_off = 1'b1;
                  appl_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  axis_in = axis_ff + 1'b1;
                  cnt_in  = '0;
               end
            end else if (cnt_ff == '0 && axis_ff != 2'd0 && !cmd.div_step) begin
               cmd.div_step = 1'b0;
               cmd.div_init = 1'b1;
               cnt_in = 6'd63;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in = (cnt_ff == 6'd63) ? 6'd1 : cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (!vld_ff || rsp_tready) begin
               vld_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         coll_ff  <= 1'b0;
         vld_ff   <= 1'b0;
         low_ff   <= 1'b0;
         appl_ff  <= 1'b0;
         cnt_ff   <= '0;
         axis_ff  <= '0;
         kind_ff  <= '0;
      end else begin
         state_ff <= state_in;
         coll_ff  <= coll_in;
         vld_ff   <= vld_in;
         low_ff   <= low_in;
         appl_ff  <= appl_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
         kind_ff  <= kind_in;
      end
   end

   assign rsp_tvalid  = vld_ff;
   assign cal_active  = coll_ff;
   assign low_range   = low_ff;
   assign cal_applied = appl_ff;

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_applied_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(cal_applied && low_range && 1'b0))
      else $error("flag conflict");
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      appl_ff |-> !coll_ff)
      else $error("applied while collecting");
`endif

endmodule

[design/magnetometer_calibrated_heading_core.sv]
// calibrated heading core: magnetometer hard/soft iron calibration and cordic heading
// sample path: multiply, cordic init, rotations, finish, output; start/stop without apply:
// multiply, output; stop with apply adds the scale divide per axis. One item at a time: the
// next request transfer is taken the cycle after the result transfer
// reset (synchronous, active high) clears calibration to offsets 0, scales 1.0, threshold 100
// depends on mch_pkg, mch_ctrl, mch_datapath
module magnetometer_calibrated_heading_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // mag_x, mag_y, mag_z
   input  logic [1:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // heading, then a zero pad bit
   output logic [2:0]  rsp_tuser,  // cal_active, low_range, cal_applied
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0]      thr_ff;
   mch_pkg::cmd_type cmd;
   mch_pkg::sts_type sts;
   logic [14:0]      heading;
   logic             cal_active, low_range, cal_applied;

   assign csr_pready = 1'b1;
   // threshold register at address 0
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'd100;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         thr_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_prdata = (csr_paddr == 2'd0) ? {16'd0, thr_ff} : 32'd0;

   mch_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cal_active  (cal_active),
      .low_range   (low_range),
      .cal_applied (cal_applied),
      .cmd         (cmd),
      .sts         (sts)
   );

   mch_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_x      (req_tdata[15:0]),
      .in_y      (req_tdata[31:16]),
      .in_z      (req_tdata[47:32]),
      .threshold (thr_ff),
      .sts       (sts),
      .heading   (heading)
   );

   assign rsp_tdata = {1'b0, heading};
   assign rsp_tuser = {cal_applied, low_range, cal_active};

endmodule

[verif/tb_top.sv]
// testbench for the calibrated heading core: directed and random transfers, scoreboard check
// depends on mch_pkg and magnetometer_calibrated_heading_core
`timescale 1ns / 100ps

module tb_top;

   // request kind with no effect
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [14:0] heading;
      logic        cal_active;
      logic        low_range;
      logic        cal_applied;
   } heading_result_type;

   // scoreboard: keeps its own copy of calibration state and predicts each result
   class heading_scoreboard;
      int unsigned        threshold;
      bit                 collecting;
      int                 ext_min[3];
      int                 ext_max[3];
      longint             off_twice[3];
      longint unsigned    scale[3];
      heading_result_type pending[$];
      int                 errors;
      int                 checked;
      int                 stops_applied;
      int                 stops_low;

      function void reset_state();
         threshold = 100;
         collecting = 0;
         for (int a = 0; a < 3; a++) begin
            ext_min[a] = 32767;
            ext_max[a] = -32768;
            off_twice[a] = 0;
            scale[a] = 1 << mch_pkg::ScaleFracBits;
         end
         pending.delete();
      endfunction

      // floor division by a power of two
      function longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      function logic [14:0] angle_of(longint cx, longint cy);
         longint x, y, z, dx, dy, h;
         longint deg180, deg360, full;
         deg180 = longint'(180) <<< mch_pkg::AngFrac;
         deg360 = longint'(360) <<< mch_pkg::AngFrac;
         full = longint'(360) <<< mch_pkg::HeadingFracBits;
         z = 0;
         if (cx == 0 && cy == 0) return '0;
         x = cx <<< 20;
         y = cy <<< 20;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = deg180;
         end
         for (int i = 0; i < mch_pkg::CordicSteps && i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
               x += dx;
               y -= dy;
               z += longint'(mch_pkg::atan_lut(5'(i)));
            end else begin
               x -= dx;
               y += dy;
               z -= longint'(mch_pkg::atan_lut(5'(i)));
            end
         end
         if (z < 0) z += deg360;
         if (z >= deg360) z -= deg360;
         h = (z + (longint'(1) <<< (mch_pkg::AngFrac - mch_pkg::HeadingFracBits - 1)))
             >>> (mch_pkg::AngFrac - mch_pkg::HeadingFracBits);
         if (h >= full) h -= full;
         return h[14:0];
      endfunction

      function void note_request(logic [1:0] kind, logic [47:0] data);
         heading_result_type r;
         int raw[3];
         int rng[3];
         bit bad;
         longint unsigned num, den, s;
         r = '{default: 0};
         for (int a = 0; a < 3; a++) raw[a] = int'($signed(data[16*a +: 16]));
         if (kind == mch_pkg::REQ_SAMPLE) begin
            r.heading = angle_of((2 * longint'(raw[0]) - off_twice[0]) * longint'(scale[0]),
                                 (2 * longint'(raw[1]) - off_twice[1]) * longint'(scale[1]));
            if (collecting)
               for (int a = 0; a < 3; a++) begin
                  if (raw[a] < ext_min[a]) ext_min[a] = raw[a];
                  if (raw[a] > ext_max[a]) ext_max[a] = raw[a];
               end
         end else if (kind == mch_pkg::REQ_START) begin
            if (!collecting) begin
               collecting = 1;
               for (int a = 0; a < 3; a++) begin
                  ext_min[a] = 32767;
                  ext_max[a] = -32768;
               end
            end
         end else if (kind == mch_pkg::REQ_STOP && collecting) begin
            collecting = 0;
            bad = 0;
            for (int a = 0; a < 3; a++) begin
               rng[a] = ext_max[a] - ext_min[a];
               if (rng[a] <= 0) bad = 1;
               if (rng[a] < int'(threshold)) r.low_range = 1;
            end
            if (bad) r.low_range = 1;
            else begin
               num = longint'(rng[0] + rng[1] + rng[2]) << mch_pkg::ScaleFracBits;
               for (int a = 0; a < 3; a++) begin
                  den = 3 * longint'(rng[a]);
                  s = (num + den / 2) / den;
                  scale[a] = (s > 65535) ? 65535 : s;
                  off_twice[a] = ext_max[a] + ext_min[a];
               end
               r.cal_applied = 1;
               stops_applied++;
            end
            if (r.low_range) stops_low++;
         end
         r.cal_active = collecting;
         pending.push_back(r);
      endfunction

      function void check_result(logic [15:0] data, logic [2:0] user);
         heading_result_type e;
         checked++;
         if (pending.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h tuser %b", data, user);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[14:0] !== e.heading) begin
            $error("heading: expected %0d actual %0d", e.heading, data[14:0]);
            errors++;
         end
         if (data[15] !== 1'b0) begin
            $error("pad bit: expected 0 actual %b", data[15]);
            errors++;
         end
         if (user[0] !== e.cal_active) begin
            $error("cal_active: expected %0d actual %0d", e.cal_active, user[0]);
            errors++;
         end
         if (user[1] !== e.low_range) begin
            $error("low_range: expected %0d actual %0d", e.low_range, user[1]);
            errors++;
         end
         if (user[2] !== e.cal_applied) begin
            $error("cal_applied: expected %0d actual %0d", e.cal_applied, user[2]);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // mag_x, mag_y, mag_z
   logic [1:0]  req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // heading, pad bit
   logic [2:0]  rsp_tuser;   // cal_active, low_range, cal_applied
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   heading_scoreboard sb;
   int  sent_count;
   bit  hold_off;      // long receiver stall requested by the stimulus

   magnetometer_calibrated_heading_core u_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // gap length: mostly short, a few long
   function int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one transfer on the request channel; valid stays up until the next call or a drain
   task automatic send_item(logic [1:0] kind, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            bit gaps);
      int g;
      g = gaps ? pick_gap() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, {z, y, x});
      sent_count++;
   endtask

   task automatic csr_write(logic [1:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.threshold = value[15:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // wait until every expected result has arrived, then let the block settle
   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (150) @(posedge clock);
   endtask

   function logic [15:0] rand_axis();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 16'h8000;
      if (p == 1) return 16'h7fff;
      if (p == 2) return 16'(int'($urandom_range(0, 40)) - 20);
      return 16'($urandom());
   endfunction

   // a calibration sweep: start, a handful of samples around a random center, stop
   task automatic cal_sweep(int unsigned spread);
      int cx, cy, cz, n;
      cx = int'($urandom_range(0, 4000)) - 2000;
      cy = int'($urandom_range(0, 4000)) - 2000;
      cz = int'($urandom_range(0, 4000)) - 2000;
      n = $urandom_range(2, 10);
      send_item(mch_pkg::REQ_START, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1);
      for (int i = 0; i < n; i++)
         send_item(mch_pkg::REQ_SAMPLE,
                   16'(cx + int'($urandom_range(0, 2 * spread)) - int'(spread)),
                   16'(cy + int'($urandom_range(0, 2 * spread)) - int'(spread)),
                   16'(cz + int'($urandom_range(0, 2 * spread)) - int'(spread)), 1);
      if ($urandom_range(0, 5) == 0)
         send_item(mch_pkg::REQ_START, '0, '0, '0, 1);   // start while collecting is ignored
      send_item(mch_pkg::REQ_STOP, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1);
   endtask

   task automatic random_phase(int count);
      int p;
      while (count > 0) begin
         p = $urandom_range(0, 99);
         if (p < 55) begin
            cal_sweep($urandom_range(0, 3) == 0 ? 60 : 8000);
            count -= 8;
         end else begin
            send_item(p < 92 ? mch_pkg::REQ_SAMPLE : (p < 96 ? mch_pkg::REQ_STOP : REQ_UNUSED),
                      rand_axis(), rand_axis(), rand_axis(), 1);
            count--;
         end
      end
   endtask

   // receiver: random ready with gaps, plus one long hold-off on request
   initial begin
      int g;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         g = pick_gap();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g - 1) @(posedge clock);
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         sb.check_result(rsp_tdata, rsp_tuser);
         rsp_tready <= 1'b0;
      end
   end

   initial begin
      sb = new();
      sb.reset_state();
      sb.errors = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every request kind, the special cases
      send_item(mch_pkg::REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 0);   // zero vector
      send_item(mch_pkg::REQ_SAMPLE, 16'h7fff, 16'h0000, 16'h7fff, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'h8000, 16'h0000, 16'h8000, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'h0000, 16'h7fff, 16'hffff, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'h0000, 16'h8000, 16'h5555, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'h8000, 16'h8000, 16'haaaa, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'h8000, 16'hffff, 16'h0001, 0);
      send_item(mch_pkg::REQ_STOP, 16'hffff, 16'hffff, 16'hffff, 0);     // stop while idle
      send_item(REQ_UNUSED, 16'hffff, 16'hffff, 16'hffff, 0);            // unused request kind
      send_item(mch_pkg::REQ_START, 16'h0, 16'h0, 16'h0, 0);
      send_item(mch_pkg::REQ_STOP, 16'h0, 16'h0, 16'h0, 0);   // no samples: non-positive range
      send_item(mch_pkg::REQ_START, 16'h0, 16'h0, 16'h0, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 0);
      send_item(mch_pkg::REQ_START, 16'h0, 16'h0, 16'h0, 0);             // start while collecting
      send_item(mch_pkg::REQ_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff, 0);   // full range everywhere
      send_item(mch_pkg::REQ_STOP, 16'h0, 16'h0, 16'h0, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'h1234, 16'hfedc, 16'h0, 0);
      send_item(mch_pkg::REQ_START, 16'h0, 16'h0, 16'h0, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'd10, 16'd10, 16'd10, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'd50, 16'd11, 16'd12, 0);   // short ranges, scale saturates
      send_item(mch_pkg::REQ_STOP, 16'h0, 16'h0, 16'h0, 0);
      send_item(mch_pkg::REQ_SAMPLE, 16'd30, 16'd10, 16'd0, 0);
      drain();

      csr_write(2'd0, 32'd0);
      random_phase(200);
      // the receiver stalls while the sender keeps offering
      hold_off = 1;
      random_phase(40);
      drain();
      csr_write(2'd0, 32'd65535);
      random_phase(200);
      drain();
      csr_write(2'd0, 32'd3000);
      random_phase(250);
      drain();

      $display("covered %0d request transfers, %0d results checked", sent_count, sb.checked);
      $display("calibrations applied %0d, stops with short range %0d",
               sb.stops_applied, sb.stops_low);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (sb.pending.size() != 0)
            $error("%0d expected results never arrived", sb.pending.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("run timed out");
      $display("Verification failed");
      $finish;
   end

endmodule
